>>> hw/rtl/bblur_pkg.sv
// bblur_pkg: shared types and constants for the 3x3 box blur block
// holds request/result payload structs, register indexes, op codes and fsm states
// no dependencies
`default_nettype none

package bblur_pkg;

    // frame size limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // derived widths
    localparam int COL_W    = $clog2(MAX_WIDTH);       // column index
    localparam int OROW_W   = $clog2(MAX_HEIGHT);      // output row index
    localparam int IROW_W   = OROW_W + 1;              // input row runs past the height
    localparam int WIDTH_W  = 11;                      // frame_width register
    localparam int HEIGHT_W = 13;                      // frame_height register
    localparam int CFG_W    = 13;                      // widest register
    localparam int CFG_IDX_W = 2;
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // op codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // reset values of the registers
    localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // request payload
    typedef struct packed {
        logic              op;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } req_t;

    // result payload
    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              last_of_frame;
    } rsp_t;

    // control states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADV,
        S_FETCH,
        S_SUM,
        S_DIV,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/box_blur_3x3_edge_aware.sv
// box_blur_3x3_edge_aware: streaming 3x3 box blur of an rgb frame
// line buffers in one synchronous memory, window, rounding divider, output register
// depends on bblur_pkg
//
// Pixels enter in raster order; each result is the per-channel mean of the 3x3
// neighborhood, leaving out neighbors outside the frame and rounding half up.
// Results lag the input by one row plus one pixel, and after the last pixel of
// the frame one flush request per pending result drains the tail (flushes sent
// earlier, and pixels sent while the tail drains, are dropped with no result).
// Writing either size register restarts the frame. A dropped request is taken
// and discarded; a request that moves the window without a result goes through
// the memory read, then window update and line write-back; a request that
// yields a result goes on from there to the neighbor sum and the bit-per-cycle
// divider (8 steps); the first flush of a single-row frame makes a second line
// read. A finished result waits in the output register while the next request
// is already taken. No clearing pass after reset.
`default_nettype none

module box_blur_3x3_edge_aware (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [bblur_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bblur_pkg::CFG_W-1:0]         cfg_data,
    // request channel
    input  wire logic                                src_valid,
    output logic                                     src_ready,
    input  wire bblur_pkg::req_t                     src_data,
    // result channel
    output logic                                     dst_valid,
    input  wire logic                                dst_ready,
    output bblur_pkg::rsp_t                          dst_data
);

    localparam int CW  = bblur_pkg::COL_W;
    localparam int IRW = bblur_pkg::IROW_W;
    localparam int ORW = bblur_pkg::OROW_W;
    localparam int WW  = bblur_pkg::WIDTH_W;
    localparam int HW  = bblur_pkg::HEIGHT_W;
    localparam int PW  = bblur_pkg::PIX_W;
    localparam int CH  = bblur_pkg::CHAN_W;
    localparam int SUM_W = CH + 4;          // nine 8-bit values
    localparam int NUM_W = SUM_W + 1;       // 2*sum + count
    localparam int DEN_W = 5;               // 2*count, up to 18

    // state and configuration
    bblur_pkg::state_t state_reg, state_next;
    logic [WW-1:0]  width_reg;
    logic [HW-1:0]  height_reg;
    logic [CW-1:0]  in_col_reg;
    logic [IRW-1:0] in_row_reg;
    logic [CW-1:0]  out_col_reg;
    logic [ORW-1:0] out_row_reg;

    // item and window
    logic [PW-1:0]  pix_reg;
    logic           flush_reg;
    logic [PW-1:0]  win_reg [9];
    logic [8:0]     mask_reg;
    logic           last_reg;

    // line memory: upper line in the high half, lower line in the low half
    logic [2*PW-1:0] line_mem [bblur_pkg::MAX_WIDTH];
    logic [2*PW-1:0] line_rd_reg;
    logic            mem_re;
    logic            mem_we;

    // divider
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg [3];
    logic [CH-1:0]    quo_reg [3];
    logic [2:0]       step_reg;

    // output register
    logic              dst_valid_reg;
    bblur_pkg::rsp_t   dst_data_reg;

    // control
    logic          accept;
    logic          adv_start;
    logic          out_load;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          inputs_done;
    logic          emit;

    // effective frame size, saturated
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (width_reg > WW'(bblur_pkg::MAX_WIDTH))
            w_eff = WW'(bblur_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = HW'(1);
        else if (height_reg > HW'(bblur_pkg::MAX_HEIGHT))
            h_eff = HW'(bblur_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign inputs_done = in_row_reg >= h_eff;
    assign emit        = (in_row_reg >= IRW'(2)) || (in_row_reg == IRW'(1) && in_col_reg != '0);
    assign accept      = src_valid && src_ready;
    assign adv_start   = accept && ((src_data.op == bblur_pkg::OP_PIXEL) ? !inputs_done
                                                                         : inputs_done);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bblur_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and control outputs
    always_comb
    begin
        state_next = state_reg;
        src_ready  = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            bblur_pkg::S_IDLE:
            begin
                src_ready = 1'b1;
                if (adv_start)
                begin
                    mem_re     = 1'b1;
                    state_next = bblur_pkg::S_ADV;
                end
            end
            bblur_pkg::S_ADV:
            begin
                mem_we = 1'b1;
                if (emit)
                    state_next = bblur_pkg::S_SUM;
                else if (flush_reg)
                    state_next = bblur_pkg::S_FETCH;
                else
                    state_next = bblur_pkg::S_IDLE;
            end
            bblur_pkg::S_FETCH:
            begin
                mem_re     = 1'b1;
                state_next = bblur_pkg::S_ADV;
            end
            bblur_pkg::S_SUM:
                state_next = bblur_pkg::S_DIV;
            bblur_pkg::S_DIV:
            begin
                if (&step_reg)
                    state_next = bblur_pkg::S_OUT;
            end
            bblur_pkg::S_OUT:
            begin
                if (!dst_valid_reg || dst_ready)
                begin
                    out_load   = 1'b1;
                    state_next = bblur_pkg::S_IDLE;
                end
            end
            default:
                state_next = bblur_pkg::S_IDLE;
        endcase
    end

    // line memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[in_col_reg] <= {line_rd_reg[PW-1:0], pix_reg};
        if (mem_re)
            line_rd_reg <= line_mem[in_col_reg];
    end

    // neighbor mask and frame end for the output position
    logic [8:0]     mask_next;
    logic           last_next;
    logic [CW:0]    in_col_p1;
    logic [CW:0]    out_col_p1;
    logic [ORW:0]   out_row_p1;
    logic [2:0]     rok;
    logic [2:0]     cok;

    always_comb
    begin
        in_col_p1  = {1'b0, in_col_reg} + (CW+1)'(1);
        out_col_p1 = {1'b0, out_col_reg} + (CW+1)'(1);
        out_row_p1 = {1'b0, out_row_reg} + (ORW+1)'(1);
        rok[0] = out_row_reg != '0;
        rok[1] = 1'b1;
        rok[2] = out_row_p1 < h_eff;
        cok[0] = out_col_reg != '0;
        cok[1] = 1'b1;
        cok[2] = out_col_p1 < w_eff;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mask_next[i*3+j] = rok[i] && cok[j];
            end
        end
        last_next = !rok[2] && !cok[2];
    end

    // configuration and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= bblur_pkg::FRAME_WIDTH_RST;
            height_reg  <= bblur_pkg::FRAME_HEIGHT_RST;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bblur_pkg::REG_FRAME_WIDTH:
                begin
                    width_reg   <= cfg_data[WW-1:0];
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                bblur_pkg::REG_FRAME_HEIGHT:
                begin
                    height_reg  <= cfg_data[HW-1:0];
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == bblur_pkg::S_ADV)
        begin
            if (emit && last_next)
            begin
                // frame done: everything restarts
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else
            begin
                if (in_col_p1 >= (CW+1)'(w_eff))
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + IRW'(1);
                end
                else
                    in_col_reg <= in_col_p1[CW-1:0];
                if (emit)
                begin
                    if (out_col_p1 >= (CW+1)'(w_eff))
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + ORW'(1);
                    end
                    else
                        out_col_reg <= out_col_p1[CW-1:0];
                end
            end
        end
    end

    // incoming pixel and window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg   <= '0;
            flush_reg <= 1'b0;
            mask_reg  <= '0;
            last_reg  <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            if (adv_start)
            begin
                flush_reg <= src_data.op == bblur_pkg::OP_FLUSH;
                if (src_data.op == bblur_pkg::OP_FLUSH)
                    pix_reg <= '0;
                else
                    pix_reg <= {src_data.in_red, src_data.in_green, src_data.in_blue};
            end
            else if (state_reg == bblur_pkg::S_FETCH)
                flush_reg <= 1'b0;
            if (state_reg == bblur_pkg::S_ADV)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k*3+0] <= win_reg[k*3+1];
                    win_reg[k*3+1] <= win_reg[k*3+2];
                end
                win_reg[2] <= line_rd_reg[2*PW-1:PW];
                win_reg[5] <= line_rd_reg[PW-1:0];
                win_reg[8] <= pix_reg;
                mask_reg   <= mask_next;
                last_reg   <= last_next;
            end
        end
    end

    // masked neighbor sums and count
    logic [SUM_W-1:0] sum_c [3];
    logic [3:0]       count_c;
    logic [NUM_W-1:0] num_c [3];

    always_comb
    begin
        count_c = 4'($countones(mask_reg));
        for (int c = 0; c < 3; c++)
        begin
            sum_c[c] = '0;
            for (int k = 0; k < 9; k++)
            begin
                if (mask_reg[k])
                    sum_c[c] = sum_c[c] + SUM_W'(win_reg[k][PW-1-c*CH -: CH]);
            end
            num_c[c] = {sum_c[c], 1'b0} + NUM_W'(count_c);
        end
    end

    // restoring divider step, one quotient bit per cycle
    logic [DEN_W:0]   trial_c [3];
    logic             ge_c [3];
    logic [DEN_W-1:0] rem_step [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            trial_c[c]  = {rem_reg[c], quo_reg[c][CH-1]};
            ge_c[c]     = trial_c[c] >= {1'b0, den_reg};
            if (ge_c[c])
                rem_step[c] = DEN_W'(trial_c[c] - {1'b0, den_reg});
            else
                rem_step[c] = trial_c[c][DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (state_reg == bblur_pkg::S_SUM)
            step_reg <= '0;
        else if (state_reg == bblur_pkg::S_DIV)
            step_reg <= step_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bblur_pkg::S_SUM)
        begin
            den_reg <= {count_c, 1'b0};
            for (int c = 0; c < 3; c++)
            begin
                rem_reg[c] <= num_c[c][NUM_W-1:CH];
                quo_reg[c] <= num_c[c][CH-1:0];
            end
        end
        else if (state_reg == bblur_pkg::S_DIV)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rem_reg[c] <= rem_step[c];
                quo_reg[c] <= {quo_reg[c][CH-2:0], ge_c[c]};
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dst_valid_reg <= 1'b0;
        else if (out_load)
            dst_valid_reg <= 1'b1;
        else if (dst_ready)
            dst_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            dst_data_reg.out_red       <= quo_reg[0];
            dst_data_reg.out_green     <= quo_reg[1];
            dst_data_reg.out_blue      <= quo_reg[2];
            dst_data_reg.last_of_frame <= last_reg;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

    // divisor stays within 2..18 while dividing
    a_den_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bblur_pkg::S_DIV |-> den_reg >= DEN_W'(2) && den_reg <= DEN_W'(18))
        else $error("divisor out of range");

    // partial remainder below divisor, so the quotient fits in a channel
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bblur_pkg::S_DIV |->
            rem_reg[0] < den_reg && rem_reg[1] < den_reg && rem_reg[2] < den_reg)
        else $error("divider remainder not below divisor");

    // line data is used only in the cycle after a read
    a_read_before_use: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bblur_pkg::S_ADV |->
            $past(state_reg) == bblur_pkg::S_IDLE || $past(state_reg) == bblur_pkg::S_FETCH)
        else $error("window update without a line read");

    // input column stays inside the frame
    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (WW'(in_col_reg) < w_eff))
        else $error("input column beyond frame width");

endmodule

`default_nettype wire
